[design/sbce_pkg.sv]
// ----------------------------------------------------------------------------
// sbce_pkg
// Shared types and constants for the sensor bank change event block.
// ----------------------------------------------------------------------------
package sbce_pkg;

  // Sensor levels in one module byte
  localparam int unsigned LEVEL_BITS = 8;
  localparam int unsigned BIT_IDX_W  = 3;
  localparam int unsigned ADDR_W     = 7;
  localparam int unsigned SENSOR_W   = 11;

  // Store word: watch flag above the last byte seen
  localparam int unsigned STORE_W = LEVEL_BITS + 1;

  // Request kinds
  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_WATCH  = 1'b1;

  typedef logic [STORE_W-1:0] store_word_t;

  // Control sequence of the top level
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } sbce_state_e;

endpackage

[design/sensor_bank_change_events.sv]
// ----------------------------------------------------------------------------
// sensor_bank_change_events
// Watches sensor module bytes per bus and address and emits one item per
// changed sensor bit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one request per item:
//   a watch request sets the watch flag of a bus and address, a report
//   carries a sensor byte. Output channel (out_valid_o / out_ready_i)
//   gives one item per changed bit of a watched report, lowest bit first,
//   with last_event_o marking the final one of that report.
//   Sequence and rate: a request is accepted, the state word is read in the
//   next cycle and written back in the same cycle it is examined, then
//   events leave at one per cycle while the receiver is ready. A new
//   request is taken only back in the idle state, after the write-back and
//   after the last event of the request before it has left.
//   Requests outside the configured buses or addresses are dropped in the
//   cycle they are taken.
//   Reset: a clearing pass writes zeros to all NUM_BUSES*ADDRS_PER_BUS
//   entries, one a cycle; in_ready_o stays low for those cycles.
//   Stall: while the receiver holds out_ready_i low the current event
//   holds and no new request is taken.
// ----------------------------------------------------------------------------
module sensor_bank_change_events #(
  parameter int unsigned ADDRS_PER_BUS = 128,
  parameter int unsigned NUM_BUSES     = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic                                bus_id_i,
  input  logic [sbce_pkg::ADDR_W-1:0]         module_addr_i,
  input  logic [sbce_pkg::LEVEL_BITS-1:0]     sensor_byte_i,
  input  logic                                watch_on_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sbce_pkg::SENSOR_W-1:0]       sensor_number_o,
  output logic                                event_bus_o,
  output logic                                new_level_o,
  output logic                                last_event_o
);

  localparam int unsigned DEPTH = NUM_BUSES * ADDRS_PER_BUS;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  sbce_pkg::sbce_state_e state_q, state_d;

  // Latched request
  logic                              req_type_q;
  logic                              bus_q;
  logic [sbce_pkg::ADDR_W-1:0]       addr_q;
  logic [sbce_pkg::LEVEL_BITS-1:0]   byte_q;
  logic                              watch_q;
  logic [IDX_W-1:0]                  slot_q;
  logic [sbce_pkg::LEVEL_BITS-1:0]   diff_q, diff_d;

  logic                              in_fire, out_fire, in_range;
  logic [IDX_W-1:0]                  slot;
  logic                              rd_en, wr_en, clear_busy;
  sbce_pkg::store_word_t             rd_data, wr_data;
  logic [sbce_pkg::LEVEL_BITS-1:0]   old_byte, diff_now, diff_rest;
  logic                              old_watch;
  logic [sbce_pkg::BIT_IDX_W-1:0]    bit_idx;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  // Map bus and address to a store entry
  assign in_range = (32'(bus_id_i) < 32'(NUM_BUSES))
                  && (32'(module_addr_i) < 32'(ADDRS_PER_BUS));
  assign slot = IDX_W'(32'(bus_id_i) * 32'(ADDRS_PER_BUS) + 32'(module_addr_i));

  assign old_watch = rd_data[sbce_pkg::LEVEL_BITS];
  assign old_byte  = rd_data[sbce_pkg::LEVEL_BITS-1:0];
  assign diff_now  = byte_q ^ old_byte;

  // Pick the lowest pending changed bit
  always_comb begin
    bit_idx = '0;
    for (int i = sbce_pkg::LEVEL_BITS - 1; i >= 0; i--) begin
      if (diff_q[i]) begin
        bit_idx = sbce_pkg::BIT_IDX_W'(i);
      end
    end
  end
  assign diff_rest = diff_q & (diff_q - sbce_pkg::LEVEL_BITS'(1));

  // Next state, store access and handshakes
  always_comb begin
    state_d    = state_q;
    diff_d     = diff_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_data    = rd_data;
    case (state_q)
      sbce_pkg::ST_CLEAR: begin
        if (!clear_busy) begin
          state_d = sbce_pkg::ST_IDLE;
        end
      end
      sbce_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_range) begin
          rd_en   = 1'b1;
          state_d = sbce_pkg::ST_READ;
        end
      end
      sbce_pkg::ST_READ: begin
        state_d = sbce_pkg::ST_IDLE;
        if (req_type_q == sbce_pkg::REQ_WATCH) begin
          wr_en   = 1'b1;
          wr_data = {watch_q, old_byte};
        end else if (old_watch) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, byte_q};
          diff_d  = diff_now;
          if (diff_now != '0) begin
            state_d = sbce_pkg::ST_EMIT;
          end
        end
      end
      sbce_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          diff_d = diff_rest;
          if (diff_rest == '0) begin
            state_d = sbce_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sbce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbce_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the request and the pending change mask
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_type_q <= req_type_i;
      bus_q      <= bus_id_i;
      addr_q     <= module_addr_i;
      byte_q     <= sensor_byte_i;
      watch_q    <= watch_on_i;
      slot_q     <= slot;
    end
    diff_q <= diff_d;
  end

  sbce_store #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_addr_i   (slot),
    .rd_data_o   (rd_data),
    .wr_en_i     (wr_en),
    .wr_addr_i   (slot_q),
    .wr_data_i   (wr_data),
    .clear_busy_o(clear_busy)
  );

  // Event fields
  assign sensor_number_o = {1'b0, addr_q, bit_idx} + sbce_pkg::SENSOR_W'(1);
  assign event_bus_o     = bus_q;
  assign new_level_o     = byte_q[bit_idx];
  assign last_event_o    = (diff_rest == '0);

  // Checks
  a_emit_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (diff_q != '0))
    else $error("event shown with no pending change");

  a_one_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while an event is pending");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_event_o) |=> (!out_valid_o && in_ready_o))
    else $error("events continue after the last one");

  a_write_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == sbce_pkg::ST_READ))
    else $error("store written outside the read-modify-write step");

endmodule

[design/sbce_store.sv]
// ----------------------------------------------------------------------------
// sbce_store
// State memory with one read port and one write port, one word per bus and
// module address, with a clearing sweep after reset and a registered read.
// ----------------------------------------------------------------------------
module sbce_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output sbce_pkg::store_word_t rd_data_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  sbce_pkg::store_word_t wr_data_i,
  output logic                 clear_busy_o
);

  sbce_pkg::store_word_t mem_q [DEPTH];
  sbce_pkg::store_word_t rd_data_q;
  logic                  clearing_q, clearing_d;
  logic [IDX_W-1:0]      clr_cnt_q, clr_cnt_d;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  sbce_pkg::store_word_t wdata;

  // Advance the clearing sweep, one entry a cycle
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + IDX_W'(1);
      if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // Select the write source: sweep first, then the user port
  always_comb begin
    we    = clearing_q | wr_en_i;
    waddr = clearing_q ? clr_cnt_q : wr_addr_i;
    wdata = clearing_q ? '0 : wr_data_i;
  end

  // Memory array with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign clear_busy_o = clearing_q;

endmodule

[tb/sbce_event_checker.sv]
// ----------------------------------------------------------------------------
// sbce_event_checker
// Watches both channels of the sensor bank change event block. It keeps its
// own copy of the watch flags and stored sensor bytes, works out the change
// events each accepted request must cause, and compares every event item
// that leaves the block with the oldest event still outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sbce_event_checker
  import sbce_pkg::*;
#(
  parameter int unsigned ADDRS_PER_BUS = 128,
  parameter int unsigned NUM_BUSES     = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  req_type_i,
  input  logic                  bus_id_i,
  input  logic [ADDR_W-1:0]     module_addr_i,
  input  logic [LEVEL_BITS-1:0] sensor_byte_i,
  input  logic                  watch_on_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [SENSOR_W-1:0]   sensor_number_i,
  input  logic                  event_bus_i,
  input  logic                  new_level_i,
  input  logic                  last_event_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int unsigned DEPTH       = NUM_BUSES * ADDRS_PER_BUS;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_number;
    logic                event_bus;
    logic                new_level;
    logic                last_event;
  } sensor_event_t;

  logic [LEVEL_BITS-1:0] level_store [DEPTH];
  logic                  watch_flag  [DEPTH];
  sensor_event_t         event_q     [$];
  int                    fail_count;

  // Count a bad event item; print only the first few
  task automatic note_failure(string what, sensor_event_t exp_ev, sensor_event_t got_ev);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $write("%0t checker: %s: expected sensor %0d bus %0d level %0d last %0d, ",
             $time, what, exp_ev.sensor_number, exp_ev.event_bus, exp_ev.new_level,
             exp_ev.last_event);
      $display("got sensor %0d bus %0d level %0d last %0d",
               got_ev.sensor_number, got_ev.event_bus, got_ev.new_level,
               got_ev.last_event);
    end
  endtask

  // Update flags and store, queue one event per changed bit, lowest first
  task automatic predict_request(logic req, logic bus, logic [ADDR_W-1:0] addr,
                                 logic [LEVEL_BITS-1:0] levels, logic won);
    int unsigned           slot;
    logic [LEVEL_BITS-1:0] diff;
    sensor_event_t         ev;
    if (bus >= NUM_BUSES || addr >= ADDRS_PER_BUS) return;
    slot = bus * ADDRS_PER_BUS + addr;
    if (req == REQ_WATCH) begin
      watch_flag[slot] = won;
      return;
    end
    if (!watch_flag[slot]) return;
    diff = levels ^ level_store[slot];
    for (int b = 0; b < LEVEL_BITS; b++) begin
      if (diff[b]) begin
        ev.sensor_number = SENSOR_W'(addr * LEVEL_BITS + b + 1);
        ev.event_bus     = bus;
        ev.new_level     = levels[b];
        ev.last_event    = ((diff >> b) >> 1) == '0;
        event_q.push_back(ev);
      end
    end
    level_store[slot] = levels;
  endtask

  // Compare one event item with the oldest outstanding event
  task automatic check_event(sensor_event_t got_ev);
    sensor_event_t exp_ev;
    if (event_q.size() == 0) begin
      note_failure("event item with none outstanding", '0, got_ev);
    end else begin
      exp_ev = event_q.pop_front();
      if (got_ev.sensor_number !== exp_ev.sensor_number ||
          got_ev.event_bus     !== exp_ev.event_bus     ||
          got_ev.new_level     !== exp_ev.new_level     ||
          got_ev.last_event    !== exp_ev.last_event) begin
        note_failure("event mismatch", exp_ev, got_ev);
      end
    end
  endtask

  // Sample both channels at each edge; results are taken before new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        level_store[i] = '0;
        watch_flag[i]  = 1'b0;
      end
      event_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_event({sensor_number_i, event_bus_i, new_level_i, last_event_i});
      end
      if (in_valid_i && in_ready_i) begin
        predict_request(req_type_i, bus_id_i, module_addr_i, sensor_byte_i, watch_on_i);
      end
    end
    pending_o    <= event_q.size();
    fail_count_o <= fail_count;
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives watch requests and sensor reports into the sensor bank change event
// block: a directed pass over the address and byte extremes and the ignored
// and unchanged cases, then random traffic aimed at a small set of watched
// modules. The receiver stalls at random and once holds off for a long
// stretch. The checker beside the block judges every event item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sbce_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned POOL         = 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 12;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  req_type    = REQ_REPORT;
  logic                  bus_id      = 1'b0;
  logic [ADDR_W-1:0]     module_addr = '0;
  logic [LEVEL_BITS-1:0] sensor_byte = '0;
  logic                  watch_on    = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [SENSOR_W-1:0]   sensor_number;
  logic                  event_bus;
  logic                  new_level;
  logic                  last_event;

  int          fail_count;
  int          pending;
  int unsigned cycles  = 0;
  int unsigned sent    = 0;
  int unsigned rx_stall = 0;
  logic        hold_off = 1'b0;

  // Stimulus memory: modules the random part keeps revisiting
  logic                  pool_bus    [POOL];
  logic [ADDR_W-1:0]     pool_addr   [POOL];
  logic [LEVEL_BITS-1:0] pool_levels [POOL];

  sensor_bank_change_events u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .bus_id_i       (bus_id),
    .module_addr_i  (module_addr),
    .sensor_byte_i  (sensor_byte),
    .watch_on_i     (watch_on),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sensor_number_o(sensor_number),
    .event_bus_o    (event_bus),
    .new_level_o    (new_level),
    .last_event_o   (last_event)
  );

  sbce_event_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .bus_id_i       (bus_id),
    .module_addr_i  (module_addr),
    .sensor_byte_i  (sensor_byte),
    .watch_on_i     (watch_on),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .sensor_number_i(sensor_number),
    .event_bus_i    (event_bus),
    .new_level_i    (new_level),
    .last_event_i   (last_event),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, calm stretches, and the long hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if ((cycles % 3000) < 600) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_stall  <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hold the receiver off once the random part is under way, so the block fills
  initial begin
    int unsigned held;
    wait (sent >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offer one item after an optional gap and hold it until accepted
  task automatic send_req(logic req, logic bus, logic [ADDR_W-1:0] addr,
                          logic [LEVEL_BITS-1:0] levels, logic won, int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    bus_id      <= bus;
    module_addr <= addr;
    sensor_byte <= levels;
    watch_on    <= won;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Drop valid and wait until every outstanding event has left the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned           p;
    int unsigned           r;
    int unsigned           gap;
    logic [LEVEL_BITS-1:0] lv;

    pool_bus[0] = 1'b0; pool_addr[0] = '0;
    pool_bus[1] = 1'b1; pool_addr[1] = '1;
    pool_bus[2] = 1'b0; pool_addr[2] = '1;
    pool_bus[3] = 1'b1; pool_addr[3] = '0;
    for (int i = 4; i < POOL; i++) begin
      pool_bus[i]  = 1'($urandom_range(0, 1));
      pool_addr[i] = ADDR_W'($urandom_range(0, 127));
    end
    for (int i = 0; i < POOL; i++) pool_levels[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unwatched, full byte changes, unchanged byte, address extremes,
    // watch cleared and set again, ignored fields carrying values
    send_req(REQ_REPORT, 1'b0, 7'd0,   8'hff, 1'b0, pick_gap());
    send_req(REQ_WATCH,  1'b0, 7'd0,   8'h5a, 1'b1, pick_gap());
    send_req(REQ_REPORT, 1'b0, 7'd0,   8'hff, 1'b0, pick_gap());
    send_req(REQ_REPORT, 1'b0, 7'd0,   8'hff, 1'b0, pick_gap());
    send_req(REQ_REPORT, 1'b0, 7'd0,   8'h00, 1'b1, pick_gap());
    send_req(REQ_WATCH,  1'b1, 7'd127, 8'h00, 1'b1, pick_gap());
    send_req(REQ_REPORT, 1'b1, 7'd127, 8'h80, 1'b0, pick_gap());
    send_req(REQ_REPORT, 1'b1, 7'd127, 8'h01, 1'b0, pick_gap());
    send_req(REQ_WATCH,  1'b1, 7'd127, 8'hff, 1'b0, pick_gap());
    send_req(REQ_REPORT, 1'b1, 7'd127, 8'haa, 1'b0, pick_gap());
    send_req(REQ_WATCH,  1'b1, 7'd127, 8'h00, 1'b1, pick_gap());
    send_req(REQ_REPORT, 1'b1, 7'd127, 8'haa, 1'b0, pick_gap());
    send_req(REQ_REPORT, 1'b0, 7'd127, 8'hff, 1'b0, pick_gap());
    send_req(REQ_WATCH,  1'b0, 7'd127, 8'h00, 1'b1, pick_gap());
    send_req(REQ_REPORT, 1'b0, 7'd127, 8'hff, 1'b0, pick_gap());
    send_req(REQ_WATCH,  1'b1, 7'd0,   8'h00, 1'b1, pick_gap());
    send_req(REQ_REPORT, 1'b1, 7'd0,   8'h01, 1'b0, pick_gap());
    send_req(REQ_REPORT, 1'b1, 7'd0,   8'h81, 1'b0, pick_gap());
    send_req(REQ_REPORT, 1'b1, 7'd0,   8'h7e, 1'b1, pick_gap());
    send_req(REQ_WATCH,  1'b0, 7'd0,   8'h00, 1'b0, pick_gap());
    send_req(REQ_REPORT, 1'b0, 7'd0,   8'h55, 1'b0, pick_gap());
    send_req(REQ_WATCH,  1'b0, 7'd0,   8'h00, 1'b1, pick_gap());
    send_req(REQ_REPORT, 1'b0, 7'd0,   8'h55, 1'b0, pick_gap());

    // Pause the sender until the block has drained
    wait_idle();

    // Random: mostly reports to revisited modules, some watch changes, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_idle();
      gap = (((n / 40) % 4) == 1) ? 0 : pick_gap();
      r   = $urandom_range(0, 99);
      p   = $urandom_range(0, POOL - 1);
      lv  = pool_levels[p];
      if (r < 10) begin
        send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 ADDR_W'($urandom_range(0, 127)), LEVEL_BITS'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), gap);
      end else if (r < 25) begin
        send_req(REQ_WATCH, pool_bus[p], pool_addr[p], LEVEL_BITS'($urandom_range(0, 255)),
                 $urandom_range(0, 3) != 0, gap);
      end else begin
        case ($urandom_range(0, 5))
          0, 1: lv = LEVEL_BITS'($urandom_range(0, 255));
          2, 3: lv = lv ^ (8'h01 << $urandom_range(0, 7));
          4:    lv = ~lv;
          default: ;
        endcase
        pool_levels[p] = lv;
        send_req(REQ_REPORT, pool_bus[p], pool_addr[p], lv, 1'($urandom_range(0, 1)), gap);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
